// ----- rtl/slle_pkg.sv -----
// Shared types, codes and sizes for the static linked list engine.
package slle_pkg;

   localparam int DEPTH      = 256;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int POS_W      = 8;
   localparam int VALUE_W    = 32;
   localparam int LEN_W      = 8;
   localparam int STATUS_W   = 2;
   localparam int CMP_W      = ((IDX_W > POS_W) ? IDX_W : POS_W) + 1;

   localparam logic [IDX_W-1:0] FREE_SLOT = '0;
   localparam logic [IDX_W-1:0] HEAD_SLOT = IDX_W'(DEPTH - 1);
   localparam logic [IDX_W-1:0] COUNT_MAX = IDX_W'(DEPTH - 2);

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_DELETE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_POS = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

   typedef struct packed {
      logic               cmd;
      logic [POS_W-1:0]   position;
      logic [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [LEN_W-1:0]    length;
   } rsp_type;

   typedef struct packed {
      logic                  en;
      logic [IDX_W-1:0]      addr;
      logic [DATA_WIDTH-1:0] data;
   } store_wr_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_INS_FREE,
      ST_INS_POP,
      ST_WALK,
      ST_INS_LINK,
      ST_DEL_UNLINK,
      ST_DEL_FREE,
      ST_DEL_PUSH,
      ST_FINISH
   } state_type;

endpackage

// ----- rtl/static_linked_list_engine.sv -----
// Top level of the static linked list engine: sequencer, element store, result register.
//
// Ordered list kept in a cursor array of DEPTH slots. A request on req_ asks to
// insert req_data.value before 1-based req_data.position (cmd 0) or to delete the
// element at that position (cmd 1). Each request gives exactly one result on rsp_:
// a status (ok, bad position, no free slot) and the list length afterwards.
// A request is taken when req_valid is high and req_stall is low; likewise rsp_.
// One request is worked at a time; req_stall stays high until its result has
// been moved to the output register. Each request first checks its position.
// An insert then pops a slot off the free list, walks to the predecessor and
// links the new slot in; a delete walks to the predecessor, unlinks the element
// and pushes its slot back on the free list. A bad position or a full store
// ends the request early. The walk follows the links one position at a time
// through the registered read port of the link RAM; the longest is position 254.
// After reset the link RAM is rebuilt by a clearing pass over all DEPTH slots
// (256 here), during which no request is taken. While the receiver stalls the
// result waits in the output register; one further request may be accepted and
// worked, and its result is held until the register frees.
module static_linked_list_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  slle_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output slle_pkg::rsp_type rsp_data
);
   import slle_pkg::*;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_data_ff;
   logic         out_free;
   logic         result_load;
   rsp_type      result;
   store_wr_type store_wr;

   logic [DATA_WIDTH-1:0] element_store_ff [DEPTH];

   slle_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_data    (req_data),
      .req_stall   (req_stall),
      .out_free    (out_free),
      .result_load (result_load),
      .result      (result),
      .store_wr    (store_wr)
   );

   always_ff @(posedge clock) begin
      if (store_wr.en) begin
         element_store_ff[store_wr.addr] <= store_wr.data;
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (result_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result_load) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- rtl/slle_ram.sv -----
// Simple dual-port RAM: one write port, one registered read port.
module slle_ram #(
   parameter int ADDR_W = 8,
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);
   localparam int WORDS = 1 << ADDR_W;

   logic [DATA_W-1:0] mem_ff [WORDS];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/slle_ctrl.sv -----
// Sequencer that walks and relinks the cursor array through one link RAM port pair.
module slle_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  slle_pkg::req_type     req_data,
   output logic                  req_stall,
   input  logic                  out_free,
   output logic                  result_load,
   output slle_pkg::rsp_type     result,
   output slle_pkg::store_wr_type store_wr
);
   import slle_pkg::*;

   state_type state_ff, state_in;

   logic                  cmd_ff, cmd_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [VALUE_W-1:0]    value_ff, value_in;
   logic [IDX_W-1:0]      count_ff, count_in;
   logic [IDX_W-1:0]      addr_ff, addr_in;
   logic [POS_W-1:0]      rem_ff, rem_in;
   logic [IDX_W-1:0]      slot_ff, slot_in;
   logic [IDX_W-1:0]      pred_ff, pred_in;
   logic [IDX_W-1:0]      victim_ff, victim_in;
   logic [STATUS_W-1:0]   status_ff, status_in;

   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [IDX_W-1:0]      wr_data;
   logic                  rd_en;
   logic [IDX_W-1:0]      rd_addr;
   logic [IDX_W-1:0]      rd_data;

   logic [CMP_W-1:0]      pos_limit;
   logic                  bad_pos;
   logic                  walk_done;
   logic                  clear_last;
   logic [IDX_W-1:0]      init_link;

   slle_ram #(
      .ADDR_W (IDX_W),
      .DATA_W (IDX_W)
   ) u_links (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // insert may target one past the tail, delete only an existing element
   assign pos_limit  = CMP_W'(count_ff) + ((cmd_ff == CMD_INSERT) ? CMP_W'(1) : CMP_W'(0));
   assign bad_pos    = (pos_ff == '0) || (CMP_W'(pos_ff) > pos_limit);
   assign walk_done  = (rem_ff == '0);
   assign clear_last = (addr_ff == HEAD_SLOT);
   assign init_link  = (addr_ff < COUNT_MAX) ? addr_ff + 1'b1 : '0;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:      state_in = clear_last ? ST_IDLE : ST_CLEAR;
         ST_IDLE:       state_in = req_valid ? ST_CHECK : ST_IDLE;
         ST_CHECK: begin
            if (bad_pos) begin
               state_in = ST_FINISH;
            end else if (cmd_ff == CMD_INSERT) begin
               state_in = ST_INS_FREE;
            end else begin
               state_in = ST_WALK;
            end
         end
         ST_INS_FREE:   state_in = (rd_data == FREE_SLOT) ? ST_FINISH : ST_INS_POP;
         ST_INS_POP:    state_in = ST_WALK;
         ST_WALK: begin
            if (walk_done) begin
               state_in = (cmd_ff == CMD_INSERT) ? ST_INS_LINK : ST_DEL_UNLINK;
            end
         end
         ST_INS_LINK:   state_in = ST_FINISH;
         ST_DEL_UNLINK: state_in = ST_DEL_FREE;
         ST_DEL_FREE:   state_in = ST_DEL_PUSH;
         ST_DEL_PUSH:   state_in = ST_FINISH;
         ST_FINISH:     state_in = out_free ? ST_IDLE : ST_FINISH;
         default:       state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd_in        = cmd_ff;
      pos_in        = pos_ff;
      value_in      = value_ff;
      count_in      = count_ff;
      addr_in       = addr_ff;
      rem_in        = rem_ff;
      slot_in       = slot_ff;
      pred_in       = pred_ff;
      victim_in     = victim_ff;
      status_in     = status_ff;
      wr_en         = 1'b0;
      wr_addr       = addr_ff;
      wr_data       = rd_data;
      rd_en         = 1'b0;
      rd_addr       = HEAD_SLOT;
      req_stall     = 1'b1;
      result_load   = 1'b0;
      store_wr.en   = 1'b0;
      store_wr.addr = slot_ff;
      store_wr.data = DATA_WIDTH'(value_ff);
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = addr_ff;
            wr_data = init_link;
            addr_in = addr_ff + 1'b1;
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd_in   = req_data.cmd;
               pos_in   = req_data.position;
               value_in = req_data.value;
            end
         end
         ST_CHECK: begin
            status_in = STATUS_OK;
            if (bad_pos) begin
               status_in = STATUS_BAD_POS;
            end else if (cmd_ff == CMD_INSERT) begin
               rd_en   = 1'b1;
               rd_addr = FREE_SLOT;
            end else begin
               rd_en   = 1'b1;
               rd_addr = HEAD_SLOT;
               addr_in = HEAD_SLOT;
               rem_in  = pos_ff - 1'b1;
            end
         end
         ST_INS_FREE: begin
            if (rd_data == FREE_SLOT) begin
               status_in = STATUS_FULL;
            end else begin
               slot_in = rd_data;
               rd_en   = 1'b1;
               rd_addr = rd_data;
            end
         end
         ST_INS_POP: begin
            // advance the free head, park the value, start the walk
            wr_en       = 1'b1;
            wr_addr     = FREE_SLOT;
            wr_data     = rd_data;
            store_wr.en = 1'b1;
            rd_en       = 1'b1;
            rd_addr     = HEAD_SLOT;
            addr_in     = HEAD_SLOT;
            rem_in      = pos_ff - 1'b1;
         end
         ST_WALK: begin
            if (walk_done) begin
               pred_in = addr_ff;
               if (cmd_ff == CMD_INSERT) begin
                  wr_en   = 1'b1;
                  wr_addr = slot_ff;
                  wr_data = rd_data;
               end else begin
                  victim_in = rd_data;
                  rd_en     = 1'b1;
                  rd_addr   = rd_data;
               end
            end else begin
               rd_en   = 1'b1;
               rd_addr = rd_data;
               addr_in = rd_data;
               rem_in  = rem_ff - 1'b1;
            end
         end
         ST_INS_LINK: begin
            wr_en    = 1'b1;
            wr_addr  = pred_ff;
            wr_data  = slot_ff;
            count_in = count_ff + 1'b1;
         end
         ST_DEL_UNLINK: begin
            wr_en   = 1'b1;
            wr_addr = pred_ff;
            wr_data = rd_data;
            rd_en   = 1'b1;
            rd_addr = FREE_SLOT;
         end
         ST_DEL_FREE: begin
            wr_en   = 1'b1;
            wr_addr = victim_ff;
            wr_data = rd_data;
         end
         ST_DEL_PUSH: begin
            wr_en    = 1'b1;
            wr_addr  = FREE_SLOT;
            wr_data  = victim_ff;
            count_in = count_ff - 1'b1;
         end
         ST_FINISH: begin
            result_load = out_free;
         end
         default: begin
            addr_in = '0;
         end
      endcase
   end

   assign result.status = status_ff;
   assign result.length = LEN_W'(count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         count_ff <= '0;
         addr_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         addr_ff  <= addr_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      pos_ff    <= pos_in;
      value_ff  <= value_in;
      rem_ff    <= rem_in;
      slot_ff   <= slot_in;
      pred_ff   <= pred_in;
      victim_ff <= victim_in;
      status_ff <= status_in;
   end

   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (wr_addr != rd_addr))
      else $error("link RAM read and write hit the same slot");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_MAX)
      else $error("list length exceeds usable slots");

   a_insert_counts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INS_LINK) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("insert did not bump the length");

   a_victim_valid: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_WALK) && walk_done && (cmd_ff == CMD_DELETE))
      |-> (rd_data != FREE_SLOT))
      else $error("delete walk ended on a null link");

endmodule
